### hw/rtl/assert_macros.svh
// Assertion helpers; the enclosing scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define RTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/rti_pkg.sv
package rti_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 24;
  localparam int CFG_IDX_W       = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } cfg_reg_t;

  // Flags that travel beside the divider data
  typedef struct packed {
    logic miss;
    logic tneg;
  } div_side_t;

endpackage

### hw/rtl/ray_triangle_intersect.sv
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | vert_a/b/c x,y,z
// out_    | output    | out_valid/out_stall | hit, t_distance, t_saturated
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// Accepts one triangle per cycle while no result is stalled at the output.
// Most of the pipeline depth is the divider for t, which resolves one quotient bit per stage.
// Synchronous active-low reset clears the valid bits and the ray registers.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic signed [COORD_WIDTH-1:0] out_t_distance,
  output logic                          out_t_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int EW1 = W + 1;
  localparam int PW1 = 2 * EW1;
  localparam int CW  = PW1 + 1;
  localparam int DPW = EW1 + CW;
  localparam int SW  = DPW + 2;
  localparam int NW  = SW + F;
  localparam int LAT = W + 11;
  localparam int EW  = SW + 3 * F + 1;
  localparam longint unsigned EPS_RAW =
    ((64'd1 << F) + 64'd500000) / 64'd1000000;
  localparam longint unsigned EPS_Q = (EPS_RAW > 0) ? EPS_RAW : 64'd1;
  localparam logic [EW-1:0] EPS_LIM = EW'(EPS_Q) << (2 * F);

  typedef logic signed [EW1-1:0] evec_t [3];
  typedef logic signed [CW-1:0]  cvec_t [3];

  logic           en;
  logic [LAT-1:0] vld_r;

  logic signed [W-1:0] org_r [3];
  logic signed [W-1:0] dir_r [3];

  evec_t e1_s1_r, e2_s1_r, tv_s1_r;
  evec_t e1_s2_r, e2_s2_r, tv_s2_r;
  evec_t e1_s3_r, e2_s3_r, tv_s3_r;
  evec_t e1_s4_r, e2_s4_r, tv_s4_r;
  cvec_t p_s4_r, q_s4_r;

  logic signed [PW1-1:0] pa_m [3];
  logic signed [PW1-1:0] pb_m [3];
  logic signed [PW1-1:0] qa_m [3];
  logic signed [PW1-1:0] qb_m [3];
  logic signed [DPW-1:0] det_m [3];
  logic signed [DPW-1:0] un_m [3];
  logic signed [DPW-1:0] vn_m [3];
  logic signed [DPW-1:0] tn_m [3];

  logic signed [SW-1:0] det_s7_r, un_s7_r, vn_s7_r, tn_s7_r;
  logic        [SW-1:0] adet_s8_r;
  logic signed [SW-1:0] un_s8_r, vn_s8_r, tn_s8_r;
  logic        [SW-1:0] adet_s9_r, tmag_s9_r;
  logic                 miss_s9_r, tneg_s9_r;
  logic                 dneg;
  logic                 small_det, ubad, vbad;

  rti_pkg::div_side_t div_side, div_side_o;
  logic [W-1:0]       div_q;
  logic               div_ovf;
  logic               sat;
  logic [W-1:0]       tval;

  logic         hit_r, sat_r;
  logic [W-1:0] t_r;

  // Advance everything unless a finished item is held at the output
  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Ray registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rti_pkg::REG_ORG_X: org_r[0] <= cfg_data;
        rti_pkg::REG_ORG_Y: org_r[1] <= cfg_data;
        rti_pkg::REG_ORG_Z: org_r[2] <= cfg_data;
        rti_pkg::REG_DIR_X: dir_r[0] <= cfg_data;
        rti_pkg::REG_DIR_Y: dir_r[1] <= cfg_data;
        rti_pkg::REG_DIR_Z: dir_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: edges and origin offset
  always_ff @(posedge clk) begin
    if (en) begin
      e1_s1_r[0] <= EW1'(in_vert_b_x) - EW1'(in_vert_a_x);
      e1_s1_r[1] <= EW1'(in_vert_b_y) - EW1'(in_vert_a_y);
      e1_s1_r[2] <= EW1'(in_vert_b_z) - EW1'(in_vert_a_z);
      e2_s1_r[0] <= EW1'(in_vert_c_x) - EW1'(in_vert_a_x);
      e2_s1_r[1] <= EW1'(in_vert_c_y) - EW1'(in_vert_a_y);
      e2_s1_r[2] <= EW1'(in_vert_c_z) - EW1'(in_vert_a_z);
      tv_s1_r[0] <= EW1'(org_r[0]) - EW1'(in_vert_a_x);
      tv_s1_r[1] <= EW1'(org_r[1]) - EW1'(in_vert_a_y);
      tv_s1_r[2] <= EW1'(org_r[2]) - EW1'(in_vert_a_z);
    end
  end

  // Hold the edges beside the cross product multipliers
  always_ff @(posedge clk) begin
    if (en) begin
      e1_s2_r <= e1_s1_r;  e2_s2_r <= e2_s1_r;  tv_s2_r <= tv_s1_r;
      e1_s3_r <= e1_s2_r;  e2_s3_r <= e2_s2_r;  tv_s3_r <= tv_s2_r;
      e1_s4_r <= e1_s3_r;  e2_s4_r <= e2_s3_r;  tv_s4_r <= tv_s3_r;
    end
  end

  // Stages 2-4: P = D x E2, Q = T x E1
  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    rti_mul #(.WA(EW1), .WB(EW1)) u_pa (
      .clk(clk), .en(en), .a(EW1'(dir_r[J])), .b(e2_s1_r[K]), .p(pa_m[i]));
    rti_mul #(.WA(EW1), .WB(EW1)) u_pb (
      .clk(clk), .en(en), .a(EW1'(dir_r[K])), .b(e2_s1_r[J]), .p(pb_m[i]));
    rti_mul #(.WA(EW1), .WB(EW1)) u_qa (
      .clk(clk), .en(en), .a(tv_s1_r[J]), .b(e1_s1_r[K]), .p(qa_m[i]));
    rti_mul #(.WA(EW1), .WB(EW1)) u_qb (
      .clk(clk), .en(en), .a(tv_s1_r[K]), .b(e1_s1_r[J]), .p(qb_m[i]));
    always_ff @(posedge clk) begin
      if (en) begin
        p_s4_r[i] <= CW'(pa_m[i]) - CW'(pb_m[i]);
        q_s4_r[i] <= CW'(qa_m[i]) - CW'(qb_m[i]);
      end
    end
  end

  // Stages 5-6: dot product terms
  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_mul #(.WA(EW1), .WB(CW)) u_det (
      .clk(clk), .en(en), .a(e1_s4_r[i]), .b(p_s4_r[i]), .p(det_m[i]));
    rti_mul #(.WA(EW1), .WB(CW)) u_un (
      .clk(clk), .en(en), .a(tv_s4_r[i]), .b(p_s4_r[i]), .p(un_m[i]));
    rti_mul #(.WA(EW1), .WB(CW)) u_vn (
      .clk(clk), .en(en), .a(EW1'(dir_r[i])), .b(q_s4_r[i]), .p(vn_m[i]));
    rti_mul #(.WA(EW1), .WB(CW)) u_tn (
      .clk(clk), .en(en), .a(e2_s4_r[i]), .b(q_s4_r[i]), .p(tn_m[i]));
  end

  // Stage 7: sum the dot product terms
  always_ff @(posedge clk) begin
    if (en) begin
      det_s7_r <= SW'(det_m[0]) + SW'(det_m[1]) + SW'(det_m[2]);
      un_s7_r  <= SW'(un_m[0]) + SW'(un_m[1]) + SW'(un_m[2]);
      vn_s7_r  <= SW'(vn_m[0]) + SW'(vn_m[1]) + SW'(vn_m[2]);
      tn_s7_r  <= SW'(tn_m[0]) + SW'(tn_m[1]) + SW'(tn_m[2]);
    end
  end

  // Stage 8: fold the sign of det into the numerators
  assign dneg = det_s7_r[SW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      adet_s8_r <= dneg ? $unsigned(-det_s7_r) : $unsigned(det_s7_r);
      un_s8_r   <= dneg ? -un_s7_r : un_s7_r;
      vn_s8_r   <= dneg ? -vn_s7_r : vn_s7_r;
      tn_s8_r   <= dneg ? -tn_s7_r : tn_s7_r;
    end
  end

  // Stage 9: degenerate and barycentric bound checks
  assign small_det = EW'(adet_s8_r) < EPS_LIM;
  assign ubad      = un_s8_r[SW-1] || ($unsigned(un_s8_r) > adet_s8_r);
  assign vbad      = vn_s8_r[SW-1] ||
                     (((SW+1)'($unsigned(un_s8_r)) + (SW+1)'($unsigned(vn_s8_r)))
                      > (SW+1)'(adet_s8_r));

  always_ff @(posedge clk) begin
    if (en) begin
      adet_s9_r <= adet_s8_r;
      miss_s9_r <= small_det || ubad || vbad;
      tneg_s9_r <= tn_s8_r[SW-1];
      tmag_s9_r <= tn_s8_r[SW-1] ? $unsigned(-tn_s8_r) : $unsigned(tn_s8_r);
    end
  end

  // Divide |t numerator| by |det|
  assign div_side.miss = miss_s9_r;
  assign div_side.tneg = tneg_s9_r;

  rti_div #(.NW(NW), .DW(SW), .QW(W)) u_div (
    .clk   (clk),
    .en    (en),
    .num   ({tmag_s9_r, {F{1'b0}}}),
    .den   (adet_s9_r),
    .side  (div_side),
    .quo   (div_q),
    .ovf   (div_ovf),
    .side_o(div_side_o)
  );

  // Saturate and apply the sign
  assign sat  = div_ovf || (div_side_o.tneg ? (div_q[W-1] && (|div_q[W-2:0]))
                                            : div_q[W-1]);
  assign tval = sat ? (div_side_o.tneg ? {1'b1, {(W-1){1'b0}}}
                                       : {1'b0, {(W-1){1'b1}}})
                    : (div_side_o.tneg ? (-div_q) : div_q);

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= !div_side_o.miss;
      t_r   <= div_side_o.miss ? '0 : tval;
      sat_r <= !div_side_o.miss && sat;
    end
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_hit         = hit_r;
  assign out_t_distance  = t_r;
  assign out_t_saturated = sat_r;

endmodule

### hw/rtl/rti_mul.sv
// Signed multiplier, b split into two halves, two register stages.
module rti_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [WA+WB-1:0] p
);

  localparam int LO = WB / 2;

  logic signed [WA+LO:0]      pl_r;
  logic signed [WA+WB-LO-1:0] ph_r;
  logic signed [WA+WB-1:0]    p_r;

  // Form partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= a * $signed({1'b0, b[LO-1:0]});
      ph_r <= a * $signed(b[WB-1:LO]);
    end
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= $signed({ph_r, {LO{1'b0}}}) + (WA+WB)'(pl_r);
    end
  end

  assign p = p_r;

endmodule

### hw/rtl/rti_div.sv
// Pipelined restoring divider: one quotient bit per stage, overflow check first.
module rti_div #(
  parameter int NW = 126,
  parameter int DW = 102,
  parameter int QW = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [NW-1:0]            num,
  input  logic [DW-1:0]            den,
  input  rti_pkg::div_side_t       side,
  output logic [QW-1:0]            quo,
  output logic                     ovf,
  output rti_pkg::div_side_t       side_o
);

  localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [RW-1:0]      rem_r  [QW+1];
  logic [DW-1:0]      den_r  [QW+1];
  logic [QW-1:0]      q_r    [QW+1];
  logic               ovf_r  [QW+1];
  rti_pkg::div_side_t side_r [QW+1];

  // Flag quotients that do not fit in QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= RW'(num);
      den_r[0]  <= den;
      q_r[0]    <= '0;
      ovf_r[0]  <= RW'(num) >= (RW'(den) << QW);
      side_r[0] <= side;
    end
  end

  // Resolve one quotient bit per stage, MSB first
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [RW-1:0] sh_w;
    logic          ge_w;
    assign sh_w = RW'(den_r[k-1]) << (QW - k);
    assign ge_w = rem_r[k-1] >= sh_w;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge_w ? (rem_r[k-1] - sh_w) : rem_r[k-1];
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][QW-2:0], ge_w};
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign quo    = q_r[QW];
  assign ovf    = ovf_r[QW];
  assign side_o = side_r[QW];

endmodule

### hw/rtl/rti_chk.sv
`include "assert_macros.svh"

module rti_chk #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_hit,
  input logic [COORD_WIDTH-1:0] out_t_distance,
  input logic                   out_t_saturated
);

  // A missed triangle carries no distance
  `RTI_ASSERT(a_miss_zero, out_valid && !out_hit |-> out_t_distance == '0 && !out_t_saturated, "miss with nonzero t")

  // A clipped t sits at one of the range ends
  `RTI_ASSERT(a_sat_end, out_valid && out_t_saturated |-> out_hit && (out_t_distance == {1'b0, {(COORD_WIDTH-1){1'b1}}} || out_t_distance == {1'b1, {(COORD_WIDTH-1){1'b0}}}), "saturated t not at range end")

  // Input is held back only by a stalled result
  `RTI_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without output stall")

  // A stalled result stays
  `RTI_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled item dropped")

  // Reset empties the pipeline
  `RTI_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "valid after reset")

endmodule

bind ray_triangle_intersect rti_chk #(.COORD_WIDTH(COORD_WIDTH)) u_rti_chk (.*);

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CW = rti_pkg::COORD_WIDTH_DEF;
  localparam int FB = rti_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = CW + 11;
  localparam longint EPS_LSB = ((64'd1 << FB) + 500000) / 1000000;
  localparam logic signed [CW-1:0] U = 1 <<< FB;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic   hit;
    coord_t t;
    logic   sat;
  } crossing_t;

  typedef struct {
    int        ray;
    coord_t    v[9];
    bit        typed;
    crossing_t r;
  } tri_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_vert[9] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  coord_t out_t_distance;
  logic out_t_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  coord_t ray_reg[6] = '{default: '0};
  crossing_t crossings_due[$];
  tri_row_t rows[$];
  int fails = 0;
  int tx_pct = 0;
  int rx_pct = 0;

  ray_triangle_intersect uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_vert_a_x(in_vert[0]), .in_vert_a_y(in_vert[1]), .in_vert_a_z(in_vert[2]),
    .in_vert_b_x(in_vert[3]), .in_vert_b_y(in_vert[4]), .in_vert_b_z(in_vert[5]),
    .in_vert_c_x(in_vert[6]), .in_vert_c_y(in_vert[7]), .in_vert_c_z(in_vert[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_t_distance(out_t_distance),
    .out_t_saturated(out_t_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Exact Moller-Trumbore test against the current ray
  function automatic crossing_t intersect_ray(coord_t v[9]);
    wide_t a[3], b[3], c[3], o[3], d[3], e1[3], e2[3], p[3], tv[3], q[3];
    wide_t det, adet, un, vn, tn, quo, lim;
    logic dneg, tneg;
    crossing_t r;
    r = '{1'b0, '0, 1'b0};
    for (int i = 0; i < 3; i++) begin
      a[i] = v[i];
      b[i] = v[3+i];
      c[i] = v[6+i];
      o[i] = ray_reg[i];
      d[i] = ray_reg[3+i];
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      tv[i] = o[i] - a[i];
    end
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
    dneg = det < 0;
    adet = dneg ? -det : det;
    if (adet < (wide_t'(EPS_LSB) <<< (2*FB))) return r;
    un = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
    if (dneg) un = -un;
    if (un < 0 || un > adet) return r;
    q[0] = tv[1]*e1[2] - tv[2]*e1[1];
    q[1] = tv[2]*e1[0] - tv[0]*e1[2];
    q[2] = tv[0]*e1[1] - tv[1]*e1[0];
    vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    if (dneg) vn = -vn;
    if (vn < 0 || un + vn > adet) return r;
    tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (dneg) tn = -tn;
    tneg = tn < 0;
    if (tneg) tn = -tn;
    quo = (tn <<< FB) / adet;
    lim = (wide_t'(1) <<< (CW-1)) + (tneg ? 1 : 0);
    r.hit = 1'b1;
    r.sat = quo >= lim;
    if (r.sat) r.t = tneg ? CMIN : CMAX;
    else r.t = tneg ? -quo[CW-1:0] : quo[CW-1:0];
    return r;
  endfunction

  // Append one directed row
  function automatic void add_row(tri_row_t row);
    rows.insert(rows.size(), row);
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
    fails++;
  endtask

  // Check each result item against the oldest expectation; stall at random
  always @(posedge clk) begin
    crossing_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (crossings_due.size() == 0) begin
        report("unexpected item", 0, out_hit);
      end else begin
        e = crossings_due.pop_front();
        if (out_hit !== e.hit) report("hit", e.hit, out_hit);
        if (out_t_distance !== e.t) report("t_distance", e.t, out_t_distance);
        if (out_t_saturated !== e.sat) report("t_saturated", e.sat, out_t_saturated);
      end
    end
    out_stall <= ($urandom_range(0, 99) < rx_pct);
  end

  // Hold off until the pipeline has drained
  task automatic drain();
    in_valid <= 1'b0;
    while (crossings_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic load_ray(coord_t r[6]);
    rti_pkg::cfg_reg_t idx;
    idx = idx.first();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= r[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      ray_reg[i] = r[i];
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tri(coord_t v[9], bit typed, crossing_t r);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    foreach (v[i]) in_vert[i] <= v[i];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    crossings_due.insert(crossings_due.size(), typed ? r : intersect_ray(v));
  endtask

  function automatic coord_t rnd_small(int bits);
    return coord_t'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  // Mostly triangles around a point on the ray, plus loose and raw-bit noise
  function automatic void make_tri(output coord_t v[9]);
    int k;
    coord_t s, pt, r1, r2;
    longint prod;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      s = rnd_small(27);
      for (int i = 0; i < 3; i++) begin
        prod = longint'(s) * longint'(ray_reg[3+i]);
        pt = ray_reg[i] + coord_t'(prod >>> FB);
        r1 = rnd_small(27);
        r2 = rnd_small(27);
        v[i] = pt + r1;
        v[3+i] = pt + r2;
        v[6+i] = pt - r1 - r2;
      end
    end else if (k < 8) begin
      foreach (v[i]) v[i] = rnd_small(29);
    end else begin
      foreach (v[i]) v[i] = $urandom;
    end
  endfunction

  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end

  initial begin
    coord_t rays[3][6];
    coord_t r[6];
    coord_t v[9];
    crossing_t none;
    int cur;
    none = '{1'b0, '0, 1'b0};
    rays[0] = '{0, 0, 0, 0, 0, 0};
    rays[1] = '{0, 0, -U, 0, 0, U};
    rays[2] = '{0, 0, -U, 0, 0, 1};

    // Directed rows: vertices a, b, c
    add_row('{0, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1, none});
    add_row('{0, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1, none});
    add_row('{0, '{CMAX, CMIN, 0, CMIN, CMAX, U, 0, U, CMIN}, 1, none});
    // hit exactly on vertex a, b and c
    add_row('{1, '{0, 0, 0, U, 0, 0, 0, U, 0}, 1, '{1, U, 0}});
    add_row('{1, '{-U, 0, 0, 0, 0, 0, -U, U, 0}, 1, '{1, U, 0}});
    add_row('{1, '{0, -U, 0, U, -U, 0, 0, 0, 0}, 1, '{1, U, 0}});
    // on the far edge, and just outside edge u
    add_row('{1, '{-U, -U, 0, U, -U, 0, -U, U, 0}, 0, none});
    add_row('{1, '{1, 0, 0, U, 0, 0, 1, U, 0}, 0, none});
    // collinear and tiny triangles give a vanishing determinant
    add_row('{1, '{0, 0, 0, U, 0, 0, 2*U, 0, 0}, 1, none});
    add_row('{1, '{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1, none});
    // behind the origin, reversed winding, clearly outside
    add_row('{1, '{0, 0, -2*U, U, 0, -2*U, 0, U, -2*U}, 1, '{1, -U, 0}});
    add_row('{1, '{0, 0, 0, 0, U, 0, U, 0, 0}, 1, '{1, U, 0}});
    add_row('{1, '{U, U, 0, 2*U, U, 0, U, 2*U, 0}, 1, none});
    add_row('{1, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1, none});
    add_row('{1, '{CMAX, CMIN, CMAX, CMIN, CMAX, 0, 0, CMIN, CMAX}, 0, none});
    // a nearly parallel direction pushes t out of range both ways
    add_row('{2, '{0, 0, 0, 64*U, 0, 0, 0, 64*U, 0}, 1, '{1, CMAX, 1}});
    add_row('{2, '{0, 0, -2*U, 64*U, 0, -2*U, 0, 64*U, -2*U}, 1, '{1, CMIN, 1}});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_pct = 11;
    rx_pct = 71;
    cur = 0;
    foreach (rows[n]) begin
      if (rows[n].ray != cur) begin
        drain();
        load_ray(rays[rows[n].ray]);
        cur = rows[n].ray;
      end
      send_tri(rows[n].v, rows[n].typed, rows[n].r);
    end

    // Random phases, each with its own ray
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      tx_pct = (ph < 2) ? 11 : (ph < 4) ? 71 : 0;
      rx_pct = (ph < 2) ? 71 : (ph < 4) ? 11 : 0;
      unique case (ph)
        1: foreach (r[i]) r[i] = CMAX;
        3: foreach (r[i]) r[i] = CMIN;
        4: foreach (r[i]) r[i] = $urandom;
        default: begin
          for (int i = 0; i < 3; i++) r[i] = rnd_small(29);
          for (int i = 3; i < 6; i++) r[i] = rnd_small(27);
        end
      endcase
      load_ray(r);
      for (int n = 0; n < 222; n++) begin
        if (ph == 2 && n == 111) drain();
        make_tri(v);
        send_tri(v, 0, none);
      end
    end

    drain();
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
